@@ rtl/vectored_thruster_mixer_6dof_defines.svh @@
// Assertion macros used by the thruster mixer checker.
// Depends on nothing; expects clk and rst in the scope of each use.
`ifndef VECTORED_THRUSTER_MIXER_6DOF_DEFINES_SVH
`define VECTORED_THRUSTER_MIXER_6DOF_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VTM_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vtm assertion failed");

// Next-cycle implication, checked out of reset.
`define VTM_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vtm assertion failed");

`endif

@@ rtl/vtm_pkg.sv @@
// Package for the six-thruster vectored mixer: widths, register codes,
// the limit bundle and the drive saturation function. No dependencies.
`default_nettype none

package vtm_pkg;

  localparam int FRAC_BITS = 15;
  localparam int CMD_W     = 16;
  localparam int CFG_W     = 16;
  localparam int NUM_THR   = 6;
  localparam int WIDE_W    = 18;   // clamped vertical, limit and forward terms
  localparam int SUM_W     = 20;   // three-term mix sums plus negation
  localparam int PROD_W    = 32;   // coupling factor times |vertical|

  typedef logic signed [CMD_W-1:0]  cmd_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  localparam wide_t ONE     = wide_t'(1 << FRAC_BITS);
  localparam sum_t  SAT_MAX = sum_t'((1 << FRAC_BITS) - 1);

  typedef enum logic [1:0] {
    REG_VERTICAL_MAX = 2'd0,
    REG_COUPLING     = 2'd1,
    REG_ENABLE       = 2'd2,
    REG_REVERSE      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    wide_t vert;
    wide_t fwd1;
    wide_t fwd3;
    logic  low_hit;
    logic  high_hit;
  } limit_t;

  // Negate on reverse, saturate symmetrically, zero when disabled.
  function automatic cmd_t drive(sum_t mix, logic rev, logic en);
    sum_t v;
    cmd_t r;
    v = rev ? -mix : mix;
    if (v > SAT_MAX) begin
      r = cmd_t'(SAT_MAX);
    end else if (v < -SAT_MAX) begin
      r = cmd_t'(-SAT_MAX);
    end else begin
      r = cmd_t'(v);
    end
    if (!en) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/vtm_limit.sv @@
// Vertical clamp with limit flags, coupling limit and forward clamp.
// Depends on vtm_pkg.
`default_nettype none

module vtm_limit (
  input  vtm_pkg::cmd_t              vertical_cmd,
  input  vtm_pkg::cmd_t              forward_cmd,
  input  logic [vtm_pkg::CFG_W-1:0]  vertical_max,
  input  logic [vtm_pkg::CFG_W-1:0]  coupling_factor,
  output vtm_pkg::limit_t            lim
);

  vtm_pkg::wide_t vs;
  vtm_pkg::wide_t vm;
  vtm_pkg::wide_t vc;
  vtm_pkg::wide_t absv;
  vtm_pkg::wide_t lim_s;
  vtm_pkg::wide_t fs;
  logic [vtm_pkg::PROD_W-1:0] prod;
  logic [vtm_pkg::PROD_W-vtm_pkg::FRAC_BITS-1:0] shed;

  always_comb begin
    vs = vtm_pkg::wide_t'(vertical_cmd);
    vm = vtm_pkg::wide_t'({2'b00, vertical_max});

    lim.low_hit = (vs <= -vm);
    vc = vs;
    if (lim.low_hit) begin
      vc = -vm;
    end
    // Test the high limit on the value after the low clamp: with a zero
    // limit a clamped negative demand lands on the high limit too.
    lim.high_hit = (vc >= vm);
    if (lim.high_hit) begin
      vc = vm;
    end
    lim.vert = vc;

    // |vertical| never exceeds one, so 16 bits hold it.
    absv = vc[vtm_pkg::WIDE_W-1] ? -vc : vc;
    prod = coupling_factor * absv[vtm_pkg::CMD_W-1:0];
    shed = prod[vtm_pkg::PROD_W-1:vtm_pkg::FRAC_BITS];
    lim_s = vtm_pkg::ONE - vtm_pkg::wide_t'({1'b0, shed});
    if (lim_s[vtm_pkg::WIDE_W-1]) begin
      lim_s = '0;
    end

    // Limit is never negative: the lower clamp only bites on reverse
    // forward, the upper one only on ahead forward.
    fs = vtm_pkg::wide_t'(forward_cmd);
    lim.fwd1 = (fs < -lim_s) ? -lim_s : fs;
    lim.fwd3 = (fs > lim_s) ? lim_s : fs;
  end

endmodule

`default_nettype wire

@@ rtl/vtm_mix.sv @@
// Fixed mixing matrix, reverse, saturation and enable for six thrusters.
// Depends on vtm_pkg.
`default_nettype none

module vtm_mix (
  input  vtm_pkg::cmd_t                      roll_cmd,
  input  vtm_pkg::cmd_t                      yaw_cmd,
  input  vtm_pkg::cmd_t                      lateral_cmd,
  input  vtm_pkg::limit_t                    lim,
  input  logic [vtm_pkg::NUM_THR-1:0]        enable_mask,
  input  logic [vtm_pkg::NUM_THR-1:0]        reverse_mask,
  output vtm_pkg::cmd_t [vtm_pkg::NUM_THR-1:0] thr
);

  vtm_pkg::sum_t r, y, l, f1, f3, v;
  vtm_pkg::sum_t mix [vtm_pkg::NUM_THR];

  always_comb begin
    r  = vtm_pkg::sum_t'(roll_cmd);
    y  = vtm_pkg::sum_t'(yaw_cmd);
    l  = vtm_pkg::sum_t'(lateral_cmd);
    f1 = vtm_pkg::sum_t'(lim.fwd1);
    f3 = vtm_pkg::sum_t'(lim.fwd3);
    v  = vtm_pkg::sum_t'(lim.vert);

    mix[0] =  y - f1 + l;
    mix[1] = -y - f1 - l;
    mix[2] = -y + f3 + l;
    mix[3] =  y + f3 - l;
    mix[4] =  r - v;
    mix[5] = -r - v;

    for (int n = 0; n < vtm_pkg::NUM_THR; n++) begin
      thr[n] = vtm_pkg::drive(mix[n], reverse_mask[n], enable_mask[n]);
    end
  end

endmodule

`default_nettype wire

@@ rtl/vectored_thruster_mixer_6dof.sv @@
// Six-thruster vectored mixer for a six-degree-of-freedom vehicle.
// Depends on vtm_pkg, vtm_limit and vtm_mix.
//
// Each transfer on the input channel carries one command vector (roll,
// pitch, yaw, vertical, forward, lateral, signed Q1.15) and yields exactly
// one transfer on the output channel with six thruster drives and two
// vertical limit flags. The block is stateless: a command lands in an input
// register, one pass of logic (vertical clamp, one 16x16 coupling multiply,
// forward clamp, mixing sums, reverse and saturation) feeds the output
// register. Each command passes the input register and then the output
// register, and a new command is taken every cycle as long as the output
// side keeps taking results; the input register and the output register
// form a two deep pipe, so a stalled result does not stop the next command
// from being captured. The limiting path is the coupling multiply followed
// by the forward clamp and the three-term sums. Drives saturate to plus or
// minus 32767; a disabled thruster reads 0. pitch_cmd carries a zero factor
// on every thruster and is not used. The user must write the registers
// (index: vertical_max = 0, coupling_factor = 1, enable_mask = 2,
// reverse_mask = 3) only while the block is idle; the block itself does not
// enforce this. Written while idle, they take effect on the next command.
`default_nettype none

module vectored_thruster_mixer_6dof (
  input  logic                       clk,
  input  logic                       rst,

  input  logic                       cfg_write,
  input  logic [1:0]                 cfg_index,
  input  logic [vtm_pkg::CFG_W-1:0]  cfg_data,

  input  logic                       in_valid,
  output logic                       in_ready,
  input  vtm_pkg::cmd_t              roll_cmd,
  input  vtm_pkg::cmd_t              pitch_cmd,
  input  vtm_pkg::cmd_t              yaw_cmd,
  input  vtm_pkg::cmd_t              vertical_cmd,
  input  vtm_pkg::cmd_t              forward_cmd,
  input  vtm_pkg::cmd_t              lateral_cmd,

  output logic                       out_valid,
  input  logic                       out_ready,
  output vtm_pkg::cmd_t              thruster_1,
  output vtm_pkg::cmd_t              thruster_2,
  output vtm_pkg::cmd_t              thruster_3,
  output vtm_pkg::cmd_t              thruster_4,
  output vtm_pkg::cmd_t              thruster_5,
  output vtm_pkg::cmd_t              thruster_6,
  output logic                       vertical_low_hit,
  output logic                       vertical_high_hit
);

  // Configuration registers.
  logic [vtm_pkg::CFG_W-1:0]   vertical_max;
  logic [vtm_pkg::CFG_W-1:0]   coupling_factor;
  logic [vtm_pkg::NUM_THR-1:0] enable_mask;
  logic [vtm_pkg::NUM_THR-1:0] reverse_mask;

  // Input register stage.
  logic          in_q_valid;
  vtm_pkg::cmd_t roll_q, yaw_q, vert_q, fwd_q, lat_q;

  // Pipe control: the output register advances when empty or taken, the
  // input register advances when empty or when the output register does.
  logic out_advance;
  logic in_advance;

  vtm_pkg::limit_t                         lim;
  vtm_pkg::cmd_t [vtm_pkg::NUM_THR-1:0]    thr;

  assign out_advance = !out_valid || out_ready;
  assign in_advance  = !in_q_valid || out_advance;
  assign in_ready    = in_advance;

  // Register writes; unknown codes cannot occur with a two-bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertical_max    <= vtm_pkg::CFG_W'(1 << vtm_pkg::FRAC_BITS);
      coupling_factor <= '0;
      enable_mask     <= '1;
      reverse_mask    <= '0;
    end else if (cfg_write) begin
      case (vtm_pkg::cfg_reg_t'(cfg_index))
        vtm_pkg::REG_VERTICAL_MAX: vertical_max    <= cfg_data;
        vtm_pkg::REG_COUPLING:     coupling_factor <= cfg_data;
        vtm_pkg::REG_ENABLE:       enable_mask     <= cfg_data[vtm_pkg::NUM_THR-1:0];
        vtm_pkg::REG_REVERSE:      reverse_mask    <= cfg_data[vtm_pkg::NUM_THR-1:0];
        default: ;
      endcase
    end
  end

  // Capture a command on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_advance) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_advance && in_valid) begin
      roll_q <= roll_cmd;
      yaw_q  <= yaw_cmd;
      vert_q <= vertical_cmd;
      fwd_q  <= forward_cmd;
      lat_q  <= lateral_cmd;
    end
  end

  vtm_limit u_limit (
    .vertical_cmd    (vert_q),
    .forward_cmd     (fwd_q),
    .vertical_max    (vertical_max),
    .coupling_factor (coupling_factor),
    .lim             (lim)
  );

  vtm_mix u_mix (
    .roll_cmd     (roll_q),
    .yaw_cmd      (yaw_q),
    .lateral_cmd  (lat_q),
    .lim          (lim),
    .enable_mask  (enable_mask),
    .reverse_mask (reverse_mask),
    .thr          (thr)
  );

  // Output register: load a finished result, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= in_q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && in_q_valid) begin
      thruster_1        <= thr[0];
      thruster_2        <= thr[1];
      thruster_3        <= thr[2];
      thruster_4        <= thr[3];
      thruster_5        <= thr[4];
      thruster_6        <= thr[5];
      vertical_low_hit  <= lim.low_hit;
      vertical_high_hit <= lim.high_hit;
    end
  end

  // pitch_cmd has zero weight on every thruster.
  logic pitch_unused;
  assign pitch_unused = ^pitch_cmd;

endmodule

`default_nettype wire

@@ rtl/vtm_checker.sv @@
// Port-level checks for the thruster mixer, bound to the top level.
// Depends on vtm_pkg and the assertion macro header.
`default_nettype none
`include "vectored_thruster_mixer_6dof_defines.svh"

module vtm_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input vtm_pkg::cmd_t thruster_1,
  input vtm_pkg::cmd_t thruster_2,
  input vtm_pkg::cmd_t thruster_3,
  input vtm_pkg::cmd_t thruster_4,
  input vtm_pkg::cmd_t thruster_5,
  input vtm_pkg::cmd_t thruster_6,
  input logic          vertical_low_hit,
  input logic          vertical_high_hit
);

  localparam vtm_pkg::cmd_t MOST_NEG = vtm_pkg::cmd_t'(1 << (vtm_pkg::CMD_W - 1));

  // A held result keeps thruster_1, thruster_5 and both limit flags.
  `VTM_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(thruster_1) && $stable(thruster_5) && $stable(vertical_low_hit) && $stable(vertical_high_hit))

  // Drives saturate symmetrically; the most negative code never shows.
  `VTM_IMPLY(a_sym_sat, out_valid, thruster_1 != MOST_NEG && thruster_2 != MOST_NEG && thruster_3 != MOST_NEG && thruster_4 != MOST_NEG && thruster_5 != MOST_NEG && thruster_6 != MOST_NEG)

  // A consumer that takes every result never throttles the input side.
  `VTM_IMPLY(a_no_throttle, out_ready, in_ready)

  // Nothing comes out in the cycle after reset.
  `VTM_IMPLY(a_reset_empty, $past(rst), !out_valid)

endmodule

bind vectored_thruster_mixer_6dof vtm_checker u_vtm_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .thruster_1        (thruster_1),
  .thruster_2        (thruster_2),
  .thruster_3        (thruster_3),
  .thruster_4        (thruster_4),
  .thruster_5        (thruster_5),
  .thruster_6        (thruster_6),
  .vertical_low_hit  (vertical_low_hit),
  .vertical_high_hit (vertical_high_hit)
);

`default_nettype wire
